// File: rtl/nvmwt_pkg.sv
package nvmwt_pkg;

  // Largest valid percentage; read-back bytes above it mean never written
  localparam logic [7:0] PCT_MAX     = 8'd100;
  localparam logic [7:0] CODE_SYNC   = 8'd0;
  localparam logic [7:0] CODE_QUEUED = 8'd1;
  localparam logic [7:0] STATUS_BUSY = 8'd1;
  localparam logic [7:0] STATUS_OK   = 8'd0;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam int unsigned SEED_SHIFT = 4;

  localparam logic [7:0]  HYST_RESET   = 8'd5;
  localparam logic [15:0] RELOAD_RESET = 16'd6000;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_HYSTERESIS  = 2'd1;
  localparam logic [1:0] REG_WAIT_RELOAD = 2'd2;

  // Engine modes that allow a write
  localparam logic [2:0] MODE_OK   = 3'd1;
  localparam logic [2:0] MODE_HOLD = 3'd2;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_STAGED = 3'd1,
    PH_BUSY   = 3'd2,
    PH_DONE   = 3'd3,
    PH_ERR    = 3'd4
  } phase_t;

  typedef struct packed {
    logic        enable;
    logic [7:0]  hysteresis_pct;
    logic [15:0] wait_reload;
  } cfg_t;

  typedef struct packed {
    logic       func;
    logic [2:0] engine_mode;
    logic [7:0] value_pct;
    logic [7:0] manager_status;
    logic [7:0] call_code;
    logic [7:0] commit_code;
    logic [7:0] read_byte;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] wait_count;
    logic        known;
    logic [6:0]  pct;
    logic [7:0]  code;
    logic [15:0] ok_count;
    logic [15:0] fail_count;
  } state_t;

  typedef struct packed {
    logic [2:0]  store_state;
    logic [7:0]  last_code;
    logic [15:0] good_writes;
    logic [15:0] failed_writes;
    logic        stored_known;
    logic [6:0]  stored_pct;
    logic        write_issued;
    logic [6:0]  write_value;
    logic        seed_valid;
    logic [10:0] seed_value;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/nvmwt_cfg.sv
module nvmwt_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output nvmwt_pkg::cfg_t   cfg
);
  import nvmwt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable         <= 1'b0;
      cfg.hysteresis_pct <= HYST_RESET;
      cfg.wait_reload    <= RELOAD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE:      cfg.enable         <= cfg_data[0];
        REG_HYSTERESIS:  cfg.hysteresis_pct <= cfg_data[7:0];
        REG_WAIT_RELOAD: cfg.wait_reload    <= cfg_data;
        default: ;  // drop writes outside the register list
      endcase
    end
  end

endmodule

// File: rtl/nvmwt_step.sv
module nvmwt_step (
  input  nvmwt_pkg::cfg_t    cfg,
  input  nvmwt_pkg::state_t  st,
  input  nvmwt_pkg::item_t   item,
  output nvmwt_pkg::state_t  st_next,
  output nvmwt_pkg::result_t res
);
  import nvmwt_pkg::*;

  logic [7:0]  e_clamp;
  logic [6:0]  e_pct;
  logic [7:0]  hyst;
  logic [7:0]  saved8;
  logic [7:0]  diff;
  logic        mode_ok;
  logic        wr;
  logic [6:0]  wval;
  logic        seed_ok;
  logic [10:0] seed;

  assign e_clamp = (item.value_pct > PCT_MAX) ? PCT_MAX : item.value_pct;
  assign e_pct   = e_clamp[6:0];
  assign hyst    = (cfg.hysteresis_pct == 8'd0) ? 8'd1 : cfg.hysteresis_pct;
  assign saved8  = {1'b0, st.pct};
  assign diff    = (e_clamp >= saved8) ? e_clamp - saved8 : saved8 - e_clamp;
  assign mode_ok = item.engine_mode inside {MODE_OK, MODE_HOLD};

  always_comb begin
    st_next = st;
    wr      = 1'b0;
    wval    = '0;
    seed_ok = 1'b0;
    seed    = '0;
    if (cfg.enable) begin
      if (item.func) begin
        // restore: forget the stored value and rearm the wait
        st_next.phase      = PH_IDLE;
        st_next.known      = 1'b0;
        st_next.pct        = '0;
        st_next.wait_count = cfg.wait_reload;
        st_next.code       = item.call_code;
        if (item.call_code != CODE_SYNC) begin
          st_next.phase = PH_ERR;
        end else if (item.read_byte <= PCT_MAX) begin
          st_next.known = 1'b1;
          st_next.pct   = item.read_byte[6:0];
          seed_ok       = 1'b1;
          seed          = {item.read_byte[6:0], SEED_SHIFT'(0)};
        end
      end else if (st.phase == PH_BUSY) begin
        // poll the pending commit
        if (item.manager_status != STATUS_BUSY) begin
          st_next.code = item.manager_status;
          if (item.manager_status == STATUS_OK) begin
            st_next.phase    = PH_DONE;
            st_next.ok_count = sat_inc(st.ok_count);
          end else begin
            st_next.phase      = PH_ERR;
            st_next.fail_count = sat_inc(st.fail_count);
          end
        end
      end else if (st.wait_count != 16'd0) begin
        st_next.wait_count = st.wait_count - 16'd1;
      end else if (mode_ok && (!st.known || diff >= hyst)) begin
        st_next.wait_count = cfg.wait_reload;
        wr                 = 1'b1;
        wval               = e_pct;
        if (item.call_code != CODE_SYNC) begin
          st_next.code       = item.call_code;
          st_next.phase      = PH_ERR;
          st_next.fail_count = sat_inc(st.fail_count);
        end else if (item.commit_code != CODE_QUEUED) begin
          st_next.code       = item.commit_code;
          st_next.phase      = PH_ERR;
          st_next.fail_count = sat_inc(st.fail_count);
        end else begin
          st_next.code  = item.commit_code;
          st_next.phase = PH_BUSY;
          st_next.known = 1'b1;
          st_next.pct   = e_pct;
        end
      end
    end
  end

  always_comb begin
    res.store_state   = st_next.phase;
    res.last_code     = st_next.code;
    res.good_writes   = st_next.ok_count;
    res.failed_writes = st_next.fail_count;
    res.stored_known  = st_next.known;
    res.stored_pct    = st_next.known ? st_next.pct : '0;
    res.write_issued  = wr;
    res.write_value   = wval;
    res.seed_valid    = seed_ok;
    res.seed_value    = seed;
  end

endmodule

// File: rtl/nvm_value_write_throttle.sv
// Rate-limited, hysteresis-gated writer of a percentage value to non-volatile
// memory. Each accepted item yields exactly one result; the block takes one
// item per clock while in_stall is low. Each item passes through the input
// register and then the result register; its result is set by the single
// state update done between those two registers. Configuration writes are
// always ready and are registered when they transfer; write them only while
// no item is in flight. in_stall rises only when both registers hold data and
// the consumer stalls the output.
module nvm_value_write_throttle (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [2:0]  engine_mode,
  input  logic [7:0]  value_pct,
  input  logic [7:0]  manager_status,
  input  logic [7:0]  call_code,
  input  logic [7:0]  commit_code,
  input  logic [7:0]  read_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  store_state,
  output logic [7:0]  last_code,
  output logic [15:0] good_writes,
  output logic [15:0] failed_writes,
  output logic        stored_known,
  output logic [6:0]  stored_pct,
  output logic        write_issued,
  output logic [6:0]  write_value,
  output logic        seed_valid,
  output logic [10:0] seed_value
);
  import nvmwt_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;
  logic    advance;

  assign cfg_ready = 1'b1;

  nvmwt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg
  );

  // advance the input register into the result register when there is room
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item.func           <= func;
      item.engine_mode    <= engine_mode;
      item.value_pct      <= value_pct;
      item.manager_status <= manager_status;
      item.call_code      <= call_code;
      item.commit_code    <= commit_code;
      item.read_byte      <= read_byte;
    end
  end

  nvmwt_step u_step (
    .cfg,
    .st,
    .item,
    .st_next,
    .res (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.wait_count <= '0;
      st.known      <= 1'b0;
      st.pct        <= '0;
      st.code       <= '0;
      st.ok_count   <= '0;
      st.fail_count <= '0;
    end else if (item_valid && advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res <= res_next;
    end
  end

  assign store_state   = res.store_state;
  assign last_code     = res.last_code;
  assign good_writes   = res.good_writes;
  assign failed_writes = res.failed_writes;
  assign stored_known  = res.stored_known;
  assign stored_pct    = res.stored_pct;
  assign write_issued  = res.write_issued;
  assign write_value   = res.write_value;
  assign seed_valid    = res.seed_valid;
  assign seed_value    = res.seed_value;

  // a queued commit always records the value it wrote
  a_commit_records: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_issued && store_state == PH_BUSY
      |-> stored_known && stored_pct == write_value)
    else $error("queued commit did not record the written value");

  // a seed comes only with a known stored value of the same percentage
  a_seed_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid && seed_valid
      |-> stored_known && seed_value == {stored_pct, 4'b0000} && !write_issued)
    else $error("seed does not match stored value");

  // the input side stalls only with both registers full and the output stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid && out_valid && out_stall)
    else $error("input stalled without a full pipeline");

  // state changes only when an item moves into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !(item_valid && advance) |=> $stable(st))
    else $error("state changed without an item");

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nvmwt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  // Engine modes with no write permission
  localparam logic [2:0] MODE_INIT     = 3'd0;
  localparam logic [2:0] MODE_FAULT    = 3'd3;
  localparam logic [2:0] MODE_OFF      = 3'd4;
  localparam logic [2:0] MODE_OVERRIDE = 3'd5;
  localparam logic [2:0] MODE_RSVD6    = 3'd6;
  localparam logic [2:0] MODE_RSVD7    = 3'd7;

  // Failing return and status codes used by the directed part
  localparam logic [7:0] STAGE_FAIL   = 8'h7F;
  localparam logic [7:0] QUEUE_FAIL   = 8'hFE;
  localparam logic [7:0] READ_FAIL    = 8'h80;
  localparam logic [7:0] STATUS_FAULT = 8'hFF;

  typedef struct packed {
    logic    pinned;
    result_t res;
  } pin_t;

  typedef struct {
    bit          is_reg;
    logic [1:0]  idx;
    logic [15:0] data;
    item_t       it;
    bit          pinned;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [2:0]  engine_mode = '0;
  logic [7:0]  value_pct = '0;
  logic [7:0]  manager_status = '0;
  logic [7:0]  call_code = '0;
  logic [7:0]  commit_code = '0;
  logic [7:0]  read_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  store_state;
  logic [7:0]  last_code;
  logic [15:0] good_writes;
  logic [15:0] failed_writes;
  logic        stored_known;
  logic [6:0]  stored_pct;
  logic        write_issued;
  logic [6:0]  write_value;
  logic        seed_valid;
  logic [10:0] seed_value;

  nvm_value_write_throttle dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .func, .engine_mode, .value_pct, .manager_status, .call_code, .commit_code,
    .read_byte,
    .out_valid, .out_stall,
    .store_state, .last_code, .good_writes, .failed_writes, .stored_known,
    .stored_pct, .write_issued, .write_value, .seed_valid, .seed_value
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted configuration and store state
  logic        cf_enable = 1'b0;
  logic [7:0]  cf_hyst = HYST_RESET;
  logic [15:0] cf_reload = RELOAD_RESET;
  phase_t      st_phase = PH_IDLE;
  logic [15:0] st_wait = '0;
  logic        st_known = 1'b0;
  logic [6:0]  st_pct = '0;
  logic [7:0]  st_code = '0;
  logic [15:0] st_good = '0;
  logic [15:0] st_failed = '0;

  result_t     pending_results[$];
  pin_t        pinned_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic result_t advance_store(input item_t it);
    result_t    r;
    logic [7:0] level;
    logic [7:0] band;
    logic [7:0] delta;
    r = '0;
    if (cf_enable) begin
      if (it.func) begin
        st_phase = PH_IDLE;
        st_known = 1'b0;
        st_pct = '0;
        st_wait = cf_reload;
        st_code = it.call_code;
        if (it.call_code != CODE_SYNC) begin
          st_phase = PH_ERR;
        end else if (it.read_byte <= PCT_MAX) begin
          st_known = 1'b1;
          st_pct = it.read_byte[6:0];
          r.seed_valid = 1'b1;
          r.seed_value = 11'(it.read_byte) << SEED_SHIFT;
        end
      end else if (st_phase == PH_BUSY) begin
        if (it.manager_status != STATUS_BUSY) begin
          st_code = it.manager_status;
          if (it.manager_status == STATUS_OK) begin
            st_phase = PH_DONE;
            st_good = bump(st_good);
          end else begin
            st_phase = PH_ERR;
            st_failed = bump(st_failed);
          end
        end
      end else if (st_wait != 0) begin
        st_wait = st_wait - 16'd1;
      end else if (it.engine_mode == MODE_OK || it.engine_mode == MODE_HOLD) begin
        level = (it.value_pct > PCT_MAX) ? PCT_MAX : it.value_pct;
        band = (cf_hyst == 0) ? 8'd1 : cf_hyst;
        delta = (level >= {1'b0, st_pct}) ? level - {1'b0, st_pct}
                                          : {1'b0, st_pct} - level;
        if (!st_known || delta >= band) begin
          st_wait = cf_reload;
          r.write_issued = 1'b1;
          r.write_value = level[6:0];
          st_code = it.call_code;
          if (it.call_code != CODE_SYNC) begin
            st_phase = PH_ERR;
            st_failed = bump(st_failed);
          end else if (it.commit_code != CODE_QUEUED) begin
            st_code = it.commit_code;
            st_phase = PH_ERR;
            st_failed = bump(st_failed);
          end else begin
            st_code = it.commit_code;
            st_phase = PH_BUSY;
            st_known = 1'b1;
            st_pct = level[6:0];
          end
        end
      end
    end
    r.store_state = st_phase;
    r.last_code = st_code;
    r.good_writes = st_good;
    r.failed_writes = st_failed;
    r.stored_known = st_known;
    r.stored_pct = st_known ? st_pct : 7'd0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    pin_t    pin;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE:      cf_enable = cfg_data[0];
          REG_HYSTERESIS:  cf_hyst = cfg_data[7:0];
          REG_WAIT_RELOAD: cf_reload = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = advance_store(item_t'{func, engine_mode, value_pct, manager_status,
                                     call_code, commit_code, read_byte});
        if (pinned_results.size() != 0) begin
          pin = pinned_results.pop_front();
          if (pin.pinned) want = pin.res;
        end
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result transfer with nothing expected", $realtime);
        end else begin
          want = pending_results.pop_front();
          check_field("store_state", 16'(want.store_state), 16'(store_state));
          check_field("last_code", 16'(want.last_code), 16'(last_code));
          check_field("good_writes", want.good_writes, good_writes);
          check_field("failed_writes", want.failed_writes, failed_writes);
          check_field("stored_known", 16'(want.stored_known), 16'(stored_known));
          check_field("stored_pct", 16'(want.stored_pct), 16'(stored_pct));
          check_field("write_issued", 16'(want.write_issued), 16'(write_issued));
          check_field("write_value", 16'(want.write_value), 16'(write_value));
          check_field("seed_valid", 16'(want.seed_valid), 16'(seed_valid));
          check_field("seed_value", 16'(want.seed_value), 16'(seed_value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic item_t tick_it(input logic [2:0] mode, input logic [7:0] pct,
                                    input logic [7:0] status, input logic [7:0] cc,
                                    input logic [7:0] qc);
    return item_t'{1'b0, mode, pct, status, cc, qc, 8'd0};
  endfunction

  function automatic item_t restore_it(input logic [7:0] cc, input logic [7:0] rb);
    return item_t'{1'b1, MODE_INIT, 8'd0, STATUS_OK, cc, CODE_QUEUED, rb};
  endfunction

  function automatic row_t item_row(input item_t it, input bit pinned = 1'b0,
                                    input result_t res = '0);
    return '{1'b0, 2'd0, 16'd0, it, pinned, res};
  endfunction

  function automatic row_t reg_row(input logic [1:0] idx, input logic [15:0] data);
    return '{1'b1, idx, data, item_t'('0), 1'b0, result_t'('0)};
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int unsigned r;
    it.func = ($urandom_range(99) < 8);
    if ($urandom_range(99) < 70) it.engine_mode = $urandom_range(1) ? MODE_OK : MODE_HOLD;
    else it.engine_mode = 3'($urandom);
    it.value_pct = ($urandom_range(99) < 80) ? 8'($urandom_range(100)) : 8'($urandom);
    r = $urandom_range(99);
    if (r < 40) it.manager_status = STATUS_BUSY;
    else if (r < 80) it.manager_status = STATUS_OK;
    else it.manager_status = 8'($urandom);
    it.call_code = ($urandom_range(99) < 85) ? CODE_SYNC : 8'($urandom);
    it.commit_code = ($urandom_range(99) < 85) ? CODE_QUEUED : 8'($urandom);
    it.read_byte = ($urandom_range(99) < 70) ? 8'($urandom_range(100)) : 8'($urandom);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    {func, engine_mode, value_pct, manager_status, call_code, commit_code, read_byte} <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every outstanding result has been seen
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    row_t        steps[$];
    logic [7:0]  hyst;
    logic [15:0] reload;
    int unsigned count;

    steps = '{
      // disabled after reset: nothing moves
      item_row(tick_it(MODE_OK, 8'd50, STATUS_OK, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_IDLE, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 11'd0}),
      item_row(restore_it(CODE_SYNC, 8'd50), 1'b1,
               result_t'{PH_IDLE, 8'd0, 16'd0, 16'd0, 1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 11'd0}),
      reg_row(REG_ENABLE, 16'd1),
      reg_row(REG_WAIT_RELOAD, 16'd0),
      // unknown stored value always writes
      item_row(tick_it(MODE_OK, 8'd50, STATUS_OK, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_BUSY, CODE_QUEUED, 16'd0, 16'd0, 1'b1, 7'd50, 1'b1, 7'd50,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_OK, 8'd50, STATUS_BUSY, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_BUSY, CODE_QUEUED, 16'd0, 16'd0, 1'b1, 7'd50, 1'b0, 7'd0,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_OK, 8'd50, STATUS_OK, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_DONE, STATUS_OK, 16'd1, 16'd0, 1'b1, 7'd50, 1'b0, 7'd0,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_HOLD, 8'd52, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      // above range clamps to the maximum percent
      item_row(tick_it(MODE_HOLD, 8'd255, STATUS_OK, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_BUSY, CODE_QUEUED, 16'd1, 16'd0, 1'b1, 7'd100, 1'b1, 7'd100,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_OK, 8'd0, STATUS_FAULT, CODE_SYNC, CODE_QUEUED), 1'b1,
               result_t'{PH_ERR, STATUS_FAULT, 16'd1, 16'd1, 1'b1, 7'd100, 1'b0, 7'd0,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_INIT, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_FAULT, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OFF, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OVERRIDE, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_RSVD6, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_RSVD7, 8'd0, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      // failed stage still reports the offered value
      item_row(tick_it(MODE_OK, 8'd0, STATUS_OK, STAGE_FAIL, CODE_QUEUED), 1'b1,
               result_t'{PH_ERR, STAGE_FAIL, 16'd1, 16'd2, 1'b1, 7'd100, 1'b1, 7'd0,
                         1'b0, 11'd0}),
      item_row(tick_it(MODE_OK, 8'd0, STATUS_OK, CODE_SYNC, QUEUE_FAIL)),
      item_row(restore_it(CODE_SYNC, 8'd100), 1'b1,
               result_t'{PH_IDLE, CODE_SYNC, 16'd1, 16'd3, 1'b1, 7'd100, 1'b0, 7'd0,
                         1'b1, 11'd1600}),
      item_row(restore_it(CODE_SYNC, 8'd101), 1'b1,
               result_t'{PH_IDLE, CODE_SYNC, 16'd1, 16'd3, 1'b0, 7'd0, 1'b0, 7'd0,
                         1'b0, 11'd0}),
      item_row(restore_it(READ_FAIL, 8'd0), 1'b1,
               result_t'{PH_ERR, READ_FAIL, 16'd1, 16'd3, 1'b0, 7'd0, 1'b0, 7'd0,
                         1'b0, 11'd0}),
      item_row(restore_it(CODE_SYNC, 8'd255)),
      item_row(restore_it(CODE_SYNC, 8'd0)),
      // zero hysteresis acts as one percent
      reg_row(REG_HYSTERESIS, 16'd0),
      item_row(tick_it(MODE_OK, 8'd1, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OK, 8'd1, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OK, 8'd1, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      reg_row(REG_WAIT_RELOAD, 16'd2),
      reg_row(REG_HYSTERESIS, 16'd255),
      item_row(restore_it(CODE_SYNC, 8'd10)),
      item_row(tick_it(MODE_OK, 8'd200, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OK, 8'd200, STATUS_OK, CODE_SYNC, CODE_QUEUED)),
      item_row(tick_it(MODE_OK, 8'd100, STATUS_OK, CODE_SYNC, CODE_QUEUED))
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (steps[i]) begin
      if (steps[i].is_reg) begin
        wait_idle();
        write_reg(steps[i].idx, steps[i].data);
      end else begin
        pinned_results.push_back('{steps[i].pinned, steps[i].res});
        send_item(steps[i].it);
      end
    end

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: begin hyst = 8'd5; reload = 16'd0; end
        1: begin hyst = 8'd0; reload = 16'd1; end
        2: begin hyst = 8'd255; reload = 16'd3; end
        3: begin hyst = 8'($urandom_range(1, 20)); reload = 16'hFFFF; end
        4: begin hyst = 8'($urandom); reload = 16'($urandom); end
        default: begin hyst = 8'($urandom_range(12)); reload = 16'($urandom_range(4)); end
      endcase
      write_reg(REG_ENABLE, {15'($urandom), p != 4});
      write_reg(REG_HYSTERESIS, {8'($urandom), hyst});
      write_reg(REG_WAIT_RELOAD, reload);
      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 51; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 51; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase
      count = (p == 3 || p == 4) ? 120 : 340;
      for (int i = 0; i < count; i++) begin
        if (i == count / 2) wait_idle();
        send_item(rand_item());
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/nvmwt_pkg.sv
rtl/nvmwt_cfg.sv
rtl/nvmwt_step.sv
rtl/nvm_value_write_throttle.sv
bench/tb.sv
